/* rtl/linear_arrangement_crossing_counter_defines.svh */
// ---------------------------------------------------------------------------
// crossing counter assertion macros
// shared property wrappers, sampled on clock and disabled in reset
// ---------------------------------------------------------------------------
`ifndef LINEAR_ARRANGEMENT_CROSSING_COUNTER_DEFINES_SVH
`define LINEAR_ARRANGEMENT_CROSSING_COUNTER_DEFINES_SVH

// property that must hold at every edge
`define LACC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define LACC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/lacc_pkg.sv */
// ---------------------------------------------------------------------------
// lacc_pkg
// constants, codes and controller/datapath types of the crossing counter
// ---------------------------------------------------------------------------
package lacc_pkg;

   localparam int MAX_NODES  = 256;
   localparam int MAX_EDGES  = 512;
   localparam int MIN_NODES  = 4;

   localparam int NODE_W     = $clog2(MAX_NODES);
   localparam int NODE_CNT_W = 9;
   localparam int EDGE_AW    = $clog2(MAX_EDGES);
   localparam int EDGE_CW    = EDGE_AW + 1;
   localparam int CROSS_W    = 17;
   localparam int SPAN_W     = 2 * NODE_W;
   localparam int CMD_W      = 2;
   localparam int STATUS_W   = 2;

   localparam logic [CROSS_W-1:0] CROSS_MAX = '1;

   // configuration port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic CSR_IDX_NODE_COUNT = 1'b0;

   // command codes
   localparam logic [CMD_W-1:0] CMD_SET_POS  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADD_EDGE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COUNT    = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_LOAD,
      ST_SCAN,
      ST_DRAIN
   } ctrl_state_type;

   typedef struct packed {
      logic               set_pos;
      logic               add_edge;
      logic               clear_all;
      logic               count_zero;
      logic               count_done;
      logic               acc_clear;
      logic               edge_rd;
      logic               span_load;
      logic               span_scan;
      logic [EDGE_AW-1:0] index;
   } dp_cmd_type;

   typedef struct packed {
      logic [EDGE_CW-1:0] edges_stored;
      logic               count_trivial;
      logic               prep_busy;
      logic               scan_busy;
   } dp_status_type;

endpackage

/* rtl/lacc_req_if.sv */
// ---------------------------------------------------------------------------
// lacc_req_if
// request channel: command and operands with valid/ready handshake
// ---------------------------------------------------------------------------
interface lacc_req_if
   import lacc_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [NODE_W-1:0] node_a;
   logic [NODE_W-1:0] node_b;
   logic [NODE_W-1:0] position;

   modport source (output valid, command, node_a, node_b, position, input ready);
   modport sink   (input valid, command, node_a, node_b, position, output ready);
endinterface

/* rtl/lacc_rsp_if.sv */
// ---------------------------------------------------------------------------
// lacc_rsp_if
// response channel: crossing count and status with valid/ready handshake
// ---------------------------------------------------------------------------
interface lacc_rsp_if
   import lacc_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [CROSS_W-1:0]  crossings;
   logic [STATUS_W-1:0] status;

   modport source (output valid, crossings, status, input ready);
   modport sink   (input valid, crossings, status, output ready);
endinterface

/* rtl/lacc_ram.sv */
// ---------------------------------------------------------------------------
// lacc_ram
// simple dual-port ram, one write port and one registered read port
// ---------------------------------------------------------------------------
module lacc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/lacc_dp.sv */
// ---------------------------------------------------------------------------
// lacc_dp
// datapath: position and edge stores, span table, pair compare and count
// ---------------------------------------------------------------------------
`include "linear_arrangement_crossing_counter_defines.svh"

module lacc_dp
   import lacc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   input  logic [NODE_CNT_W-1:0] node_count,
   input  logic [NODE_W-1:0]     node_a,
   input  logic [NODE_W-1:0]     node_b,
   input  logic [NODE_W-1:0]     position,
   output logic [CROSS_W-1:0]    rsp_crossings,
   output logic [STATUS_W-1:0]   rsp_status
);

   logic [EDGE_CW-1:0]    edges_stored_ff, edges_stored_in;
   logic [MAX_NODES-1:0]  pos_valid_ff, pos_valid_in;

   logic [NODE_CNT_W-1:0] limit;
   logic                  a_ok, b_ok, pos_ok, store_full;
   logic                  set_ok, add_ok;

   // prep pipeline
   logic                  s1_valid_ff;
   logic [EDGE_AW-1:0]    s1_idx_ff;
   logic                  s2_valid_ff;
   logic [EDGE_AW-1:0]    s2_idx_ff;
   logic [NODE_W-1:0]     s2_first_ff, s2_second_ff;
   logic                  s2_first_ok_ff, s2_second_ok_ff;
   logic [NODE_W-1:0]     first_rd, second_rd;
   logic [NODE_W-1:0]     pos_first_rd, pos_second_rd;
   logic [NODE_W-1:0]     p, q, span_lo, span_hi;

   // pair scan
   logic                  load_q_ff, scan_q_ff;
   logic [NODE_W-1:0]     held_lo_ff, held_hi_ff;
   logic [SPAN_W-1:0]     span_rd;
   logic [NODE_W-1:0]     c, d;
   logic                  pair_cross;
   logic [CROSS_W-1:0]    acc_ff, acc_in;

   logic [CROSS_W-1:0]    rsp_crossings_ff, rsp_crossings_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic                  rsp_write;

   // range and capacity checks
   always_comb begin
      limit      = (node_count > NODE_CNT_W'(MAX_NODES)) ? NODE_CNT_W'(MAX_NODES) : node_count;
      a_ok       = {1'b0, node_a} < limit;
      b_ok       = {1'b0, node_b} < limit;
      pos_ok     = {1'b0, position} < limit;
      store_full = edges_stored_ff >= EDGE_CW'(MAX_EDGES);
      set_ok     = a_ok && pos_ok;
      add_ok     = a_ok && b_ok && !store_full;
   end

   always_comb begin
      edges_stored_in = edges_stored_ff;
      pos_valid_in    = pos_valid_ff;
      priority if (cmd.clear_all) begin
         edges_stored_in = '0;
         pos_valid_in    = '0;
      end else if (cmd.add_edge && add_ok) begin
         edges_stored_in = edges_stored_ff + EDGE_CW'(1);
      end else if (cmd.set_pos && set_ok) begin
         pos_valid_in[node_a] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edges_stored_ff <= '0;
         pos_valid_ff    <= '0;
      end else begin
         edges_stored_ff <= edges_stored_in;
         pos_valid_ff    <= pos_valid_in;
      end
   end

   // two copies of the position store so both endpoints read in the same cycle
   lacc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_pos_first (
      .clock   (clock),
      .wr_en   (cmd.set_pos && set_ok),
      .wr_addr (node_a),
      .wr_data (position),
      .rd_en   (s1_valid_ff),
      .rd_addr (first_rd),
      .rd_data (pos_first_rd)
   );

   lacc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_pos_second (
      .clock   (clock),
      .wr_en   (cmd.set_pos && set_ok),
      .wr_addr (node_a),
      .wr_data (position),
      .rd_en   (s1_valid_ff),
      .rd_addr (second_rd),
      .rd_data (pos_second_rd)
   );

   lacc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_EDGES)) u_edge_first (
      .clock   (clock),
      .wr_en   (cmd.add_edge && add_ok),
      .wr_addr (edges_stored_ff[EDGE_AW-1:0]),
      .wr_data (node_a),
      .rd_en   (cmd.edge_rd),
      .rd_addr (cmd.index),
      .rd_data (first_rd)
   );

   lacc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_EDGES)) u_edge_second (
      .clock   (clock),
      .wr_en   (cmd.add_edge && add_ok),
      .wr_addr (edges_stored_ff[EDGE_AW-1:0]),
      .wr_data (node_b),
      .rd_en   (cmd.edge_rd),
      .rd_addr (cmd.index),
      .rd_data (second_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         load_q_ff   <= 1'b0;
         scan_q_ff   <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.edge_rd;
         s2_valid_ff <= s1_valid_ff;
         load_q_ff   <= cmd.span_load;
         scan_q_ff   <= cmd.span_scan;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff       <= cmd.index;
      s2_idx_ff       <= s1_idx_ff;
      s2_first_ff     <= first_rd;
      s2_second_ff    <= second_rd;
      s2_first_ok_ff  <= pos_valid_ff[first_rd];
      s2_second_ok_ff <= pos_valid_ff[second_rd];
   end

   // a node never placed sits at its own index
   always_comb begin
      p       = s2_first_ok_ff ? pos_first_rd : s2_first_ff;
      q       = s2_second_ok_ff ? pos_second_rd : s2_second_ff;
      span_lo = (p < q) ? p : q;
      span_hi = (p < q) ? q : p;
   end

   lacc_ram #(.WIDTH(SPAN_W), .DEPTH(MAX_EDGES)) u_span (
      .clock   (clock),
      .wr_en   (s2_valid_ff),
      .wr_addr (s2_idx_ff),
      .wr_data ({span_lo, span_hi}),
      .rd_en   (cmd.span_load || cmd.span_scan),
      .rd_addr (cmd.index),
      .rd_data (span_rd)
   );

   always_ff @(posedge clock) begin
      if (load_q_ff) begin
         held_lo_ff <= span_rd[SPAN_W-1:NODE_W];
         held_hi_ff <= span_rd[NODE_W-1:0];
      end
   end

   always_comb begin
      c          = span_rd[SPAN_W-1:NODE_W];
      d          = span_rd[NODE_W-1:0];
      pair_cross = ((held_lo_ff < c) && (c < held_hi_ff) && (held_hi_ff < d))
                || ((c < held_lo_ff) && (held_lo_ff < d) && (d < held_hi_ff));
      acc_in = acc_ff;
      priority if (cmd.acc_clear) begin
         acc_in = '0;
      end else if (scan_q_ff && pair_cross && (acc_ff != CROSS_MAX)) begin
         acc_in = acc_ff + CROSS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // response payload
   always_comb begin
      rsp_write = cmd.set_pos || cmd.add_edge || cmd.clear_all
               || cmd.count_zero || cmd.count_done;
      rsp_crossings_in = cmd.count_done ? acc_ff : '0;
      priority if (cmd.set_pos) begin
         rsp_status_in = set_ok ? STATUS_OK : STATUS_RANGE;
      end else if (cmd.add_edge) begin
         if (!(a_ok && b_ok)) begin
            rsp_status_in = STATUS_RANGE;
         end else if (store_full) begin
            rsp_status_in = STATUS_FULL;
         end else begin
            rsp_status_in = STATUS_OK;
         end
      end else begin
         rsp_status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_write) begin
         rsp_crossings_ff <= rsp_crossings_in;
         rsp_status_ff    <= rsp_status_in;
      end
   end

   assign rsp_crossings = rsp_crossings_ff;
   assign rsp_status    = rsp_status_ff;

   always_comb begin
      status.edges_stored  = edges_stored_ff;
      status.count_trivial = (node_count < NODE_CNT_W'(MIN_NODES))
                          || (edges_stored_ff < EDGE_CW'(2));
      status.prep_busy     = s1_valid_ff || s2_valid_ff;
      status.scan_busy     = scan_q_ff;
   end

   `LACC_ASSERT(a_store_bound, edges_stored_ff <= EDGE_CW'(MAX_EDGES), "edge count past capacity")
   `LACC_ASSERT(a_scan_after_prep, (cmd.span_load || cmd.span_scan) |-> !status.prep_busy, "span read while span table still filling")
   `LACC_ASSERT_NEXT(a_clear_empties, cmd.clear_all, (edges_stored_ff == '0) && (pos_valid_ff == '0), "clear left edges or positions behind")

endmodule

/* rtl/lacc_ctrl.sv */
// ---------------------------------------------------------------------------
// lacc_ctrl
// controller: request decode, count sequencing over edge pairs, response
// ---------------------------------------------------------------------------
`include "linear_arrangement_crossing_counter_defines.svh"

module lacc_ctrl
   import lacc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [CMD_W-1:0] req_command,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dp_cmd_type       cmd,
   input  dp_status_type    status
);

   ctrl_state_type     state_ff, state_in;
   logic [EDGE_CW-1:0] idx_ff, idx_in;
   logic [EDGE_CW-1:0] row_ff, row_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               accept;
   logic [EDGE_CW-1:0] n, last, row_next;
   logic               rsp_write;

   assign n         = status.edges_stored;
   assign last      = n - EDGE_CW'(1);
   assign row_next  = row_ff + EDGE_CW'(1);
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_command == CMD_COUNT) && !status.count_trivial) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if ((idx_ff == n) && !status.prep_busy) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (idx_ff == last) begin
               state_in = (row_next == last) ? ST_DRAIN : ST_LOAD;
            end
         end
         ST_DRAIN: begin
            if (!status.scan_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // edge and row counters
   always_comb begin
      idx_in = idx_ff;
      row_in = row_ff;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
         end
         ST_PREP: begin
            if (idx_ff != n) begin
               idx_in = idx_ff + EDGE_CW'(1);
            end else begin
               row_in = '0;
            end
         end
         ST_LOAD: begin
            idx_in = row_next;
         end
         ST_SCAN: begin
            if (idx_ff == last) begin
               row_in = row_next;
            end else begin
               idx_in = idx_ff + EDGE_CW'(1);
            end
         end
         ST_DRAIN: begin
            idx_in = idx_ff;
         end
         default: begin
            idx_in = '0;
         end
      endcase
   end

   // datapath commands
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_command)
                  CMD_SET_POS:  cmd.set_pos   = 1'b1;
                  CMD_ADD_EDGE: cmd.add_edge  = 1'b1;
                  CMD_CLEAR:    cmd.clear_all = 1'b1;
                  CMD_COUNT: begin
                     if (status.count_trivial) begin
                        cmd.count_zero = 1'b1;
                     end else begin
                        cmd.acc_clear = 1'b1;
                     end
                  end
                  default: cmd = '0;
               endcase
            end
         end
         ST_PREP: begin
            if (idx_ff != n) begin
               cmd.edge_rd = 1'b1;
               cmd.index   = idx_ff[EDGE_AW-1:0];
            end
         end
         ST_LOAD: begin
            cmd.span_load = 1'b1;
            cmd.index     = row_ff[EDGE_AW-1:0];
         end
         ST_SCAN: begin
            cmd.span_scan = 1'b1;
            cmd.index     = idx_ff[EDGE_AW-1:0];
         end
         ST_DRAIN: begin
            cmd.count_done = !status.scan_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_write = cmd.set_pos || cmd.add_edge || cmd.clear_all
               || cmd.count_zero || cmd.count_done;
      priority if (rsp_write) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `LACC_ASSERT(a_edge_rd_in_store, cmd.edge_rd |-> (idx_ff < n), "edge read past stored edges")
   `LACC_ASSERT(a_scan_above_row, (state_ff == ST_SCAN) |-> (idx_ff > row_ff), "scan index not above held row")
   `LACC_ASSERT(a_done_slot_free, cmd.count_done |-> !rsp_valid_ff, "count finished over a pending response")

endmodule

/* rtl/linear_arrangement_crossing_counter.sv */
// ---------------------------------------------------------------------------
// linear_arrangement_crossing_counter
// edge crossing counter for a graph drawn in a linear arrangement
// ---------------------------------------------------------------------------
// Each request transaction sets a node position, appends an edge (up to 512),
// asks for the crossing count, or clears edges and positions; every request
// gives exactly one response transaction. Set, add and clear take one cycle
// and a new request is taken each cycle while the response register drains.
// A count with E stored edges (E >= 2, node_count >= 4) first streams the
// edges through the position stores into a span table, then walks every
// edge pair through the single read port of that table, loading each row's
// span before scanning the edges after it. Otherwise the count answers zero
// without a scan. Positions return to identity on reset and clear at once,
// with no sweep. node_count is written through the csr port at address 0;
// the user writes it only while idle; the block itself does not enforce it.
// ---------------------------------------------------------------------------
module linear_arrangement_crossing_counter
   import lacc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   lacc_req_if.sink          req_chan,
   lacc_rsp_if.source        rsp_chan,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   logic [NODE_CNT_W-1:0] node_count_ff, node_count_in;
   logic                  csr_sel_node_count;
   dp_cmd_type            cmd;
   dp_status_type         status;

   // configuration register
   assign csr_sel_node_count = (csr_paddr[2] == CSR_IDX_NODE_COUNT);
   assign csr_pready         = 1'b1;

   always_comb begin
      node_count_in = node_count_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_sel_node_count) begin
         node_count_in = csr_pwdata[NODE_CNT_W-1:0];
      end
      csr_prdata = csr_sel_node_count ? CSR_DW'(node_count_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= '0;
      end else begin
         node_count_ff <= node_count_in;
      end
   end

   lacc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_command (req_chan.command),
      .req_ready   (req_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .cmd         (cmd),
      .status      (status)
   );

   lacc_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .node_count    (node_count_ff),
      .node_a        (req_chan.node_a),
      .node_b        (req_chan.node_b),
      .position      (req_chan.position),
      .rsp_crossings (rsp_chan.crossings),
      .rsp_status    (rsp_chan.status)
   );

endmodule
